[rtl/core/spq_pkg.sv]
// shared types and constants for the sorted priority queue
`default_nettype none

package spq_pkg;

    localparam int SPQ_QUEUE_DEPTH   = 16;
    localparam int SPQ_PRIORITY_BITS = 8;
    localparam int SPQ_DATA_BITS     = 16;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DELETE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_spq_status;

    // operation broadcast to every cell of the chain
    typedef struct packed {
        logic ins;
        logic del;
    } t_spq_cmd;

endpackage

`default_nettype wire

[rtl/core/spq_cell.sv]
// one slot of the sorted chain: holds an entry, shifts toward tail on insert, toward head on delete
`default_nettype none

module spq_cell
    import spq_pkg::*;
#(
    parameter int PRIORITY_BITS = SPQ_PRIORITY_BITS,
    parameter int DATA_BITS     = SPQ_DATA_BITS
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  t_spq_cmd                 i_cmd,
    input  wire  [PRIORITY_BITS-1:0] i_new_priority,
    input  wire  [DATA_BITS-1:0]     i_new_data,
    input  wire                      i_prev_take,
    input  wire                      i_prev_valid,
    input  wire  [PRIORITY_BITS-1:0] i_prev_priority,
    input  wire  [DATA_BITS-1:0]     i_prev_data,
    input  wire                      i_next_valid,
    input  wire  [PRIORITY_BITS-1:0] i_next_priority,
    input  wire  [DATA_BITS-1:0]     i_next_data,
    output logic                     o_take,
    output logic                     o_valid,
    output logic [PRIORITY_BITS-1:0] o_priority,
    output logic [DATA_BITS-1:0]     o_data
);

    logic                     r_valid;
    logic                     n_valid;
    logic [PRIORITY_BITS-1:0] r_priority;
    logic [PRIORITY_BITS-1:0] n_priority;
    logic [DATA_BITS-1:0]     r_data;
    logic [DATA_BITS-1:0]     n_data;

    // empty slots and slots not above the new word belong after the insert point
    assign o_take = !r_valid || (r_priority <= i_new_priority);

    always_comb begin
        n_valid    = r_valid;
        n_priority = r_priority;
        n_data     = r_data;
        if (i_cmd.ins) begin
            if (i_prev_take) begin
                // insert point lies above: shift down one slot
                n_valid    = i_prev_valid;
                n_priority = i_prev_priority;
                n_data     = i_prev_data;
            end else if (o_take) begin
                n_valid    = 1'b1;
                n_priority = i_new_priority;
                n_data     = i_new_data;
            end
        end else if (i_cmd.del) begin
            n_valid    = i_next_valid;
            n_priority = i_next_priority;
            n_data     = i_next_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_priority <= n_priority;
        r_data     <= n_data;
    end

    assign o_valid    = r_valid;
    assign o_priority = r_priority;
    assign o_data     = r_data;

endmodule

`default_nettype wire

[rtl/core/sorted_priority_queue_top.sv]
// top level of the sorted priority queue: cell chain, entry count and result register
//
// usage
//   a command word (i_func, i_in_priority, i_in_data) is taken at a rising edge
//   where start is high and busy is low. i_func low inserts, high deletes the head.
//   the result word appears on the o_ ports in the next cycle,
//   marked by o_done; o_status, o_removed_* and o_entry_count are registered, and
//   o_head_* come straight from the first cell of the chain.
// throughput
//   one command is taken every cycle while busy is low. every cell compares its
//   own priority with the broadcast word and picks its neighbor, the new word or
//   itself, so the whole shift of the list happens in the cycle the command is taken.
// reset
//   i_rst_n is synchronous and active low. it clears the valid bit of every cell
//   and the count; busy stays high through reset and falls once r_ready is registered after it.
// receiver
//   the receiver cannot stall; each result must be captured in its o_done cycle.
`default_nettype none

module sorted_priority_queue_top
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH   = SPQ_QUEUE_DEPTH,
    parameter int PRIORITY_BITS = SPQ_PRIORITY_BITS,
    parameter int DATA_BITS     = SPQ_DATA_BITS,
    localparam int CountBits    = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      start,
    output logic                     busy,
    input  wire                      i_func,
    input  wire  [PRIORITY_BITS-1:0] i_in_priority,
    input  wire  [DATA_BITS-1:0]     i_in_data,
    output logic                     o_done,
    output logic [1:0]               o_status,
    output logic [PRIORITY_BITS-1:0] o_removed_priority,
    output logic [DATA_BITS-1:0]     o_removed_data,
    output logic [CountBits-1:0]     o_entry_count,
    output logic                     o_head_valid,
    output logic [PRIORITY_BITS-1:0] o_head_priority,
    output logic [DATA_BITS-1:0]     o_head_data
);

    logic                     r_ready;
    logic                     accept;
    logic                     full;
    logic                     empty;
    t_spq_cmd                 cmd;

    logic [CountBits-1:0]     r_count;
    logic [CountBits-1:0]     n_count;
    logic                     r_done;
    t_spq_status              r_status;
    t_spq_status              n_status;
    logic [PRIORITY_BITS-1:0] r_rem_priority;
    logic [PRIORITY_BITS-1:0] n_rem_priority;
    logic [DATA_BITS-1:0]     r_rem_data;
    logic [DATA_BITS-1:0]     n_rem_data;

    logic                     cell_take     [QUEUE_DEPTH];
    logic                     cell_valid    [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] cell_priority [QUEUE_DEPTH];
    logic [DATA_BITS-1:0]     cell_data     [QUEUE_DEPTH];

    assign busy   = !r_ready;
    assign accept = start && r_ready;
    assign full   = (r_count == CountBits'(QUEUE_DEPTH));
    assign empty  = (r_count == '0);

    always_comb begin
        cmd.ins = accept && (i_func == FUNC_INSERT) && !full;
        cmd.del = accept && (i_func == FUNC_DELETE) && !empty;
    end

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            logic                     prev_take;
            logic                     prev_valid;
            logic [PRIORITY_BITS-1:0] prev_priority;
            logic [DATA_BITS-1:0]     prev_data;
            logic                     next_valid;
            logic [PRIORITY_BITS-1:0] next_priority;
            logic [DATA_BITS-1:0]     next_data;

            if (gi == 0) begin : g_head
                assign prev_take     = 1'b0;
                assign prev_valid    = 1'b0;
                assign prev_priority = '0;
                assign prev_data     = '0;
            end else begin : g_body
                assign prev_take     = cell_take[gi-1];
                assign prev_valid    = cell_valid[gi-1];
                assign prev_priority = cell_priority[gi-1];
                assign prev_data     = cell_data[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1) begin : g_tail
                assign next_valid    = 1'b0;
                assign next_priority = '0;
                assign next_data     = '0;
            end else begin : g_inner
                assign next_valid    = cell_valid[gi+1];
                assign next_priority = cell_priority[gi+1];
                assign next_data     = cell_data[gi+1];
            end

            spq_cell #(
                .PRIORITY_BITS (PRIORITY_BITS),
                .DATA_BITS     (DATA_BITS)
            ) u_cell (
                .i_clk           (i_clk),
                .i_rst_n         (i_rst_n),
                .i_cmd           (cmd),
                .i_new_priority  (i_in_priority),
                .i_new_data      (i_in_data),
                .i_prev_take     (prev_take),
                .i_prev_valid    (prev_valid),
                .i_prev_priority (prev_priority),
                .i_prev_data     (prev_data),
                .i_next_valid    (next_valid),
                .i_next_priority (next_priority),
                .i_next_data     (next_data),
                .o_take          (cell_take[gi]),
                .o_valid         (cell_valid[gi]),
                .o_priority      (cell_priority[gi]),
                .o_data          (cell_data[gi])
            );
        end
    endgenerate

    always_comb begin
        n_count        = r_count;
        n_status       = ST_DONE;
        n_rem_priority = '0;
        n_rem_data     = '0;
        unique case (i_func)
            FUNC_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CountBits'(1);
                end
            end
            FUNC_DELETE: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count        = r_count - CountBits'(1);
                    n_rem_priority = cell_priority[0];
                    n_rem_data     = cell_data[0];
                end
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_ready <= 1'b1;
            r_done  <= accept;
            if (accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status       <= n_status;
            r_rem_priority <= n_rem_priority;
            r_rem_data     <= n_rem_data;
        end
    end

    assign o_done             = r_done;
    assign o_status           = r_status;
    assign o_removed_priority = r_rem_priority;
    assign o_removed_data     = r_rem_data;
    assign o_entry_count      = r_count;
    assign o_head_valid       = cell_valid[0];
    assign o_head_priority    = cell_valid[0] ? cell_priority[0] : '0;
    assign o_head_data        = cell_valid[0] ? cell_data[0] : '0;

endmodule

`default_nettype wire

[rtl/core/spq_checker.sv]
// port-level checks for the sorted priority queue, bound to the top level
`default_nettype none

module spq_checker
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH   = SPQ_QUEUE_DEPTH,
    parameter int PRIORITY_BITS = SPQ_PRIORITY_BITS,
    parameter int DATA_BITS     = SPQ_DATA_BITS,
    localparam int CountBits    = $clog2(QUEUE_DEPTH + 1)
) (
    input wire                     i_clk,
    input wire                     i_rst_n,
    input wire                     start,
    input wire                     busy,
    input wire                     o_done,
    input wire [1:0]               o_status,
    input wire [PRIORITY_BITS-1:0] o_removed_priority,
    input wire [DATA_BITS-1:0]     o_removed_data,
    input wire [CountBits-1:0]     o_entry_count,
    input wire                     o_head_valid
);

    // every accepted word gives exactly one result in the next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_done)
        else $error("accepted word gave no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_done)
        else $error("result without accepted word");

    a_head_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_head_valid == (o_entry_count != '0)))
        else $error("head valid disagrees with count");

    a_full_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_FULL) |->
            (o_entry_count == CountBits'(QUEUE_DEPTH) && o_removed_priority == '0
             && o_removed_data == '0))
        else $error("full rejection with queue not full");

    a_empty_delete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_EMPTY) |->
            (o_entry_count == '0 && !o_head_valid && o_removed_priority == '0))
        else $error("empty delete with entries present");

endmodule

bind sorted_priority_queue_top spq_checker #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .PRIORITY_BITS (PRIORITY_BITS),
    .DATA_BITS     (DATA_BITS)
) u_spq_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .start              (start),
    .busy               (busy),
    .o_done             (o_done),
    .o_status           (o_status),
    .o_removed_priority (o_removed_priority),
    .o_removed_data     (o_removed_data),
    .o_entry_count      (o_entry_count),
    .o_head_valid       (o_head_valid)
);

`default_nettype wire
